// ===== rtl/core/bfra_pkg.sv =====
// Shared types and constants for the bounded FIFO with running year average.
// Used by the channel interfaces and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bfra_pkg;

    // Payload field widths, fixed by the item format.
    localparam int OP_W     = 1;
    localparam int TAG_W    = 32;
    localparam int YEAR_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 3;

    // Default number of queue entries.
    localparam int DEFAULT_QUEUE_DEPTH = 5;

    // Quotient bits resolved per cycle by the averaging divider.
    localparam int DIV_RADIX_BITS = 4;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_ERR = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/bfra_if.sv =====
// Valid/ready channel interfaces for commands and results of the FIFO block.
// Depends on bfra_pkg for the payload field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bfra_cmd_if;
    import bfra_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TAG_W-1:0]  entry_tag;
    logic [YEAR_W-1:0] birth_year;

    modport source (output valid, output op, output entry_tag, output birth_year,
                    input ready);
    modport sink   (input valid, input op, input entry_tag, input birth_year,
                    output ready);
endinterface

interface bfra_res_if;
    import bfra_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [YEAR_W-1:0]   year_average;
    logic [TAG_W-1:0]    removed_tag;
    logic [YEAR_W-1:0]   removed_year;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output year_average,
                    output removed_tag, output removed_year, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input year_average,
                    input removed_tag, input removed_year, input occupancy,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfra_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module bfra_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bounded_fifo_running_average.sv =====
// Top level of the bounded FIFO with running year average.
// Depends on bfra_pkg, the channel interfaces in bfra_if and bfra_ram.
`timescale 1ns / 1ps
`default_nettype none

// A queue of up to QUEUE_DEPTH entries (tag and year) held in one RAM, with a
// running sum of the stored years. An insert on a full queue silently drops
// the oldest entry, then appends and reports the truncated average of the
// stored years. A remove pops and reports the oldest entry; a remove on an
// empty queue reports an error status and changes nothing. One command is
// handled at a time. After the command transfer the sequencer reads the head
// entry and updates the queue; a remove then goes straight to the result
// register, while an insert first passes through the averaging divider,
// which resolves four quotient bits per cycle. The next command is taken
// once its result is registered. A result that waits on the sink does not
// hold back a new command, only the loading of that command's own result.
module bounded_fifo_running_average #(
    parameter int QUEUE_DEPTH = bfra_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bfra_cmd_if.sink    cmd,
    bfra_res_if.source  res
);
    import bfra_pkg::*;

    // Derived sizes.
    localparam int AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int SW        = YEAR_W + CW;
    localparam int DIV_STEPS = (SW + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DW        = DIV_STEPS * DIV_RADIX_BITS;
    localparam int DCW       = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int MW        = TAG_W + YEAR_W;

    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(QUEUE_DEPTH);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SW-1:0]       sum_reg, sum_next;
    logic [DCW-1:0]      step_reg, step_next;

    // Latched command.
    logic [OP_W-1:0]     op_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [YEAR_W-1:0]   year_reg;

    // Pending result fields gathered before the result register.
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [TAG_W-1:0]    pend_tag_reg, pend_tag_next;
    logic [YEAR_W-1:0]   pend_year_reg, pend_year_next;

    // Divider registers: dividend shifts out as the quotient shifts in.
    logic [DW-1:0]       div_reg, div_next;
    logic [CW-1:0]       rem_reg, rem_next;

    // Result register.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [YEAR_W-1:0]   out_avg_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [YEAR_W-1:0]   out_year_reg;
    logic [OCC_W-1:0]    out_occ_reg;

    // RAM ports.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [MW-1:0]       ram_wdata;
    logic                ram_re;
    logic [MW-1:0]       ram_rdata;
    logic [TAG_W-1:0]    head_tag;
    logic [YEAR_W-1:0]   head_year;

    logic                cmd_fire;
    logic                out_load;
    logic                is_full;
    logic [AW-1:0]       head_inc;
    logic [AW:0]         tail_raw;
    logic [AW-1:0]       tail_slot;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || res.ready);

    assign head_tag  = ram_rdata[MW-1:YEAR_W];
    assign head_year = ram_rdata[YEAR_W-1:0];
    assign is_full   = (count_reg == FULL_CNT);
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;

    // Tail slot: on a full queue the new entry takes the evicted head slot.
    assign tail_raw  = {1'b0, head_reg} + (AW + 1)'(count_reg);
    assign tail_slot = is_full ? head_reg
                     : ((tail_raw >= DEPTH_EXT) ? AW'(tail_raw - DEPTH_EXT)
                                                : tail_raw[AW-1:0]);

    // The head entry is read as the command is taken; the new entry is written to the tail slot on insert.
    assign ram_re    = cmd_fire;
    assign ram_we    = (state_reg == S_READ) && (op_reg == OP_INSERT);
    assign ram_waddr = tail_slot;
    assign ram_wdata = {tag_reg, year_reg};

    bfra_ram #(
        .WIDTH  (MW),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Divider step: four restoring long-division steps on narrow values.
    always_comb
    begin
        logic [CW:0]   rem_t;
        logic [DW-1:0] div_t;
        rem_t = '0;
        div_t = div_reg;
        rem_t[CW-1:0] = rem_reg;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            rem_t = {rem_t[CW-1:0], div_t[DW-1]};
            div_t = {div_t[DW-2:0], 1'b0};
            if (rem_t >= {1'b0, count_reg})
            begin
                rem_t    = rem_t - {1'b0, count_reg};
                div_t[0] = 1'b1;
            end
        end
        div_next = div_t;
        rem_next = rem_t[CW-1:0];
    end

    // Sequencer and queue state update.
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        step_next        = step_reg;
        pend_status_next = pend_status_reg;
        pend_tag_next    = pend_tag_reg;
        pend_year_next   = pend_year_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                step_next      = DCW'(DIV_STEPS - 1);
                pend_tag_next  = '0;
                pend_year_next = '0;
                if (op_reg == OP_INSERT)
                begin
                    pend_status_next = ST_INSERTED;
                    if (is_full)
                    begin
                        head_next = head_inc;
                        sum_next  = sum_reg - SW'(head_year) + SW'(year_reg);
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + SW'(year_reg);
                    end
                    state_next = S_DIV;
                end
                else if (count_reg == '0)
                begin
                    pend_status_next = ST_EMPTY_ERR;
                    state_next       = S_OUT;
                end
                else
                begin
                    pend_status_next = ST_REMOVED;
                    pend_tag_next    = head_tag;
                    pend_year_next   = head_year;
                    head_next        = head_inc;
                    count_next       = count_reg - 1'b1;
                    sum_next         = sum_reg - SW'(head_year);
                    state_next       = S_OUT;
                end
            end
            S_DIV:
            begin
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            step_reg  <= step_next;
        end
    end

    // Command latch, pending result fields and divider datapath.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            op_reg   <= cmd.op;
            tag_reg  <= cmd.entry_tag;
            year_reg <= cmd.birth_year;
        end
        pend_status_reg <= pend_status_next;
        pend_tag_reg    <= pend_tag_next;
        pend_year_reg   <= pend_year_next;
        if (state_reg == S_READ)
        begin
            div_reg <= DW'(sum_next);
            rem_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_avg_reg    <= (pend_status_reg == ST_INSERTED) ? div_reg[YEAR_W-1:0] : '0;
            out_tag_reg    <= pend_tag_reg;
            out_year_reg   <= pend_year_reg;
            out_occ_reg    <= OCC_W'(count_reg);
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = out_status_reg;
    assign res.year_average = out_avg_reg;
    assign res.removed_tag  = out_tag_reg;
    assign res.removed_year = out_year_reg;
    assign res.occupancy    = out_occ_reg;

endmodule

`default_nettype wire
